// File: hw/rtl/pph_pkg.sv
// ----------------------------------------------------------------------------
// pph_pkg
// Shared constants, types and the entry store request for the perturbation
// probing hash table.
// ----------------------------------------------------------------------------
package pph_pkg;

    localparam int LOG2_SLOTS   = 8;
    localparam int SLOTS        = 1 << LOG2_SLOTS;
    localparam int CAPACITY     = (2 * SLOTS) / 3;
    localparam int ENTRY_W      = $clog2(CAPACITY);
    localparam int KEY_W        = 32;
    localparam int VALUE_W      = 32;
    localparam int HASH_W       = 64;
    localparam int ENTRY_NUM_W  = 8;
    localparam int STEP_SHIFT   = 5;
    localparam int PROBE_LIMIT  = SLOTS + 16;
    localparam int PROBE_W      = $clog2(PROBE_LIMIT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_SLOT,
        S_KEY,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FOUND    = 2'd1,
        ST_MISSING  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    typedef struct packed {
        logic               we;
        logic [ENTRY_W-1:0] waddr;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic               re;
        logic [ENTRY_W-1:0] raddr;
    } t_store_req;

endpackage

// File: hw/rtl/pph_entry_store.sv
// ----------------------------------------------------------------------------
// pph_entry_store
// Dense key and value store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pph_entry_store
    import pph_pkg::*;
(
    input  logic               i_clk,
    input  t_store_req         i_req,
    output logic [KEY_W-1:0]   o_key,
    output logic [VALUE_W-1:0] o_value
);

    logic [KEY_W-1:0]   mem_key [CAPACITY];
    logic [VALUE_W-1:0] mem_val [CAPACITY];
    logic [KEY_W-1:0]   r_rd_key;
    logic [VALUE_W-1:0] r_rd_value;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem_key[i_req.waddr] <= i_req.key;
            mem_val[i_req.waddr] <= i_req.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_key   <= mem_key[i_req.raddr];
            r_rd_value <= mem_val[i_req.raddr];
        end
    end

    assign o_key   = r_rd_key;
    assign o_value = r_rd_value;

endmodule

// File: hw/rtl/perturb_probe_hash_table.sv
// ----------------------------------------------------------------------------
// perturb_probe_hash_table
// Open addressing hash table with perturbation probing over a slot memory and
// a dense entry store.
// ----------------------------------------------------------------------------
// Each probe is one slot memory read and, for a lookup that finds the slot
// occupied, one entry store read and key compare; one request is in flight,
// the next is taken in the cycle after the result loads. Full inserts skip
// probing and go straight to the result. Reset is synchronous: slot valid
// bits and the entry count clear at once, no clearing pass.
// ----------------------------------------------------------------------------
module perturb_probe_hash_table
    import pph_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_cmd,
    input  logic [KEY_W-1:0]       i_key,
    input  logic [HASH_W-1:0]      i_hash,
    input  logic [VALUE_W-1:0]     i_value,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_status,
    output logic [VALUE_W-1:0]     o_value_out,
    output logic [ENTRY_NUM_W-1:0] o_entry_number
);

    t_state                r_state, n_state;
    logic [ENTRY_W-1:0]    mem_slot [SLOTS];
    logic                  r_slot_vld [SLOTS];
    logic [ENTRY_W-1:0]    r_slot_data;
    logic                  r_slot_hit;
    logic [ENTRY_W-1:0]    r_count;
    logic                  r_cmd;
    logic [KEY_W-1:0]      r_key;
    logic [VALUE_W-1:0]    r_value;
    logic [HASH_W-1:0]     r_perturb, n_perturb;
    logic [LOG2_SLOTS-1:0] r_slot, n_slot;
    logic [PROBE_W-1:0]    r_probes;
    t_status               r_res_status;
    logic [VALUE_W-1:0]    r_res_value;
    logic [ENTRY_W-1:0]    r_res_num;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [VALUE_W-1:0]    r_out_value;
    logic [ENTRY_W-1:0]    r_out_num;

    logic                  c_accept, c_full, c_lookup, c_last, c_match;
    logic                  c_slot_rd, c_insert, c_entry_rd, c_advance, c_found, c_out_load;
    t_store_req            c_req;
    logic [KEY_W-1:0]      st_key;
    logic [VALUE_W-1:0]    st_value;

    pph_entry_store u_store (
        .i_clk   (i_clk),
        .i_req   (c_req),
        .o_key   (st_key),
        .o_value (st_value)
    );

    assign c_accept = (r_state == S_IDLE) && i_in_valid;
    assign c_full   = (r_count >= ENTRY_W'(CAPACITY));
    assign c_lookup = (r_cmd == CMD_LOOKUP);
    assign c_last   = (r_probes == PROBE_W'(PROBE_LIMIT - 1));
    assign c_match  = (st_key == r_key);

    assign n_perturb = r_perturb >> STEP_SHIFT;
    assign n_slot    = r_slot + {r_slot[LOG2_SLOTS-3:0], 2'b00}
                     + n_perturb[LOG2_SLOTS-1:0] + LOG2_SLOTS'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_cmd == CMD_INSERT && c_full) ? S_DONE : S_PROBE;
                end
            end
            S_PROBE: n_state = S_SLOT;
            S_SLOT: begin
                if (!r_slot_hit) begin
                    n_state = S_DONE;
                end else if (c_lookup) begin
                    n_state = S_KEY;
                end else begin
                    n_state = c_last ? S_DONE : S_PROBE;
                end
            end
            S_KEY: begin
                if (c_match) begin
                    n_state = S_DONE;
                end else begin
                    n_state = c_last ? S_DONE : S_PROBE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        c_slot_rd  = 1'b0;
        c_insert   = 1'b0;
        c_entry_rd = 1'b0;
        c_advance  = 1'b0;
        c_found    = 1'b0;
        c_out_load = 1'b0;
        case (r_state)
            S_PROBE: c_slot_rd = 1'b1;
            S_SLOT: begin
                c_insert   = !r_slot_hit && !c_lookup;
                c_entry_rd = r_slot_hit && c_lookup;
                c_advance  = r_slot_hit && !c_lookup;
            end
            S_KEY: begin
                c_found   = c_match;
                c_advance = !c_match;
            end
            S_DONE: c_out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    always_comb begin
        c_req.we    = c_insert;
        c_req.waddr = r_count;
        c_req.key   = r_key;
        c_req.value = r_value;
        c_req.re    = c_entry_rd;
        c_req.raddr = r_slot_data;
    end

    always_ff @(posedge i_clk) begin
        r_state <= !i_rst_n ? S_IDLE : n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_slot_vld[i] <= 1'b0;
            end
        end else if (c_insert) begin
            r_slot_vld[r_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_insert) begin
            mem_slot[r_slot] <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_slot_rd) begin
            r_slot_data <= mem_slot[r_slot];
            r_slot_hit  <= r_slot_vld[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (c_insert) begin
            r_count <= r_count + ENTRY_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_cmd        <= i_cmd;
            r_key        <= i_key;
            r_value      <= i_value;
            r_perturb    <= i_hash;
            r_slot       <= i_hash[LOG2_SLOTS-1:0];
            r_probes     <= '0;
            r_res_status <= (i_cmd == CMD_LOOKUP) ? ST_MISSING : ST_FULL;
            r_res_value  <= '0;
            r_res_num    <= '0;
        end else begin
            if (c_advance) begin
                r_perturb <= n_perturb;
                r_slot    <= n_slot;
                r_probes  <= r_probes + PROBE_W'(1);
            end
            if (c_insert) begin
                r_res_status <= ST_INSERTED;
                r_res_num    <= r_count;
            end
            if (c_found) begin
                r_res_status <= ST_FOUND;
                r_res_value  <= st_value;
                r_res_num    <= r_slot_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_out_load) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
            r_out_num    <= r_res_num;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_value_out    = r_out_value;
    assign o_entry_number = ENTRY_NUM_W'(r_out_num);

endmodule
